/* hdl/opm_pkg.sv */
// opm_pkg: request codes and field widths shared by the orbit partition merge
// block and its port checker
// no dependencies
`timescale 1ns / 1ps

package opm_pkg;

	localparam int LABEL_W = 6;
	localparam int CFG_W   = 7;
	localparam int REQ_W   = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PERM  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

endpackage

/* hdl/orbit_partition_merge.sv */
// orbit_partition_merge: ordered orbit partition kept in a label/link memory
// depends on opm_pkg
`timescale 1ns / 1ps
//
// Usage
//   A request (req_type, vertex, cycle_continues) is taken when start is high
//   and busy is low. Permutation entries start or extend a cycle; a later
//   entry of a cycle merges its cell into the anchor's cell. A query streams
//   one result per cell on representative/last_of_run, marked by strobe for
//   one cycle each; the receiver cannot stall and takes every result.
//   cfg_we/cfg_wdata write n_vertices; the user is to do so only while the block is idle, which it does not enforce.
// Work per accepted request
//   anchor entry, clear, unused code: the block does not become busy
//   query: reads every position in use and sends one result per cell
//   merge: search and decision (all of it when the merge is skipped), then
//   a copy of the moved cell, a shift of the cells between the two (none
//   for adjacent cells), a rewrite of the moved cell and one link write;
//   the moved cell is the later one of the two, and each step handles
//   one entry per cycle
// Reset
//   arst_n and the clear request mark every entry as never written, which
//   reads as the discrete identity partition; no clearing pass is needed.
module orbit_partition_merge
	import opm_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [LABEL_W-1:0] vertex,
	input  logic               cycle_continues,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output logic               strobe,
	output logic [LABEL_W-1:0] representative,
	output logic               last_of_run
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = AW + 1;
	localparam int DW = LABEL_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FIND, ST_DECIDE, ST_COPY, ST_SHIFT, ST_PUT, ST_LINK, ST_QUERY
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]      n_vertices_q;
	logic [LABEL_W-1:0]    anchor_q, vert_q;
	logic                  inside_q;
	logic [CW-1:0]         cnt_q;
	logic [MAX_VERTICES-1:0] valid_q;

	logic [DW-1:0]         mem [MAX_VERTICES];
	logic [LABEL_W-1:0]    tmp [MAX_VERTICES];

	logic                  act_s1, vld_s1;
	logic [AW-1:0]         pos_s1;
	logic [DW-1:0]         rdata_s1;
	logic [LABEL_W-1:0]    tdata_s1;

	logic                  fa_q, fb_q, pa_q, pb_q;
	logic [AW-1:0]         sa_q, sb_q, ea_q, eb_q, cur_start_q;
	logic [LABEL_W-1:0]    la_q, lb_q, lab1_q, min_q;
	logic [CW-1:0]         e1_q, s2_q, e2_q, len_q;
	logic                  fresh_q;

	logic [CW-1:0]         n_use, n_last;
	logic                  rd_en, tmp_rd_en, wr_en, tmp_we;
	logic [AW-1:0]         rd_addr, wr_addr, tmp_waddr;
	logic [DW-1:0]         wr_data, word;
	logic [LABEL_W-1:0]    lab;
	logic                  cell_end, last_pos, hit_a, hit_b;
	logic [LABEL_W-1:0]    minv;
	logic                  accept;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		if (n_vertices_q == '0) n_use = CW'(1);
		else if (n_vertices_q > CFG_W'(MAX_VERTICES)) n_use = CW'(MAX_VERTICES);
		else n_use = CW'(n_vertices_q);
	end
	assign n_last = n_use - CW'(1);

	// read data with never-written entries shown as identity singletons
	assign word     = vld_s1 ? rdata_s1 : {LABEL_W'(pos_s1), 1'b0};
	assign lab      = word[DW-1:1];
	assign last_pos = (CW'(pos_s1) == n_last);
	assign cell_end = last_pos || !word[0];
	assign hit_a    = !fa_q && (lab == anchor_q);
	assign hit_b    = !fb_q && (lab == vert_q);
	assign minv     = (fresh_q || lab < min_q) ? lab : min_q;

	always_comb begin
		rd_en     = 1'b0;
		tmp_rd_en = 1'b0;
		rd_addr   = cnt_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		tmp_we    = 1'b0;
		tmp_waddr = '0;
		case (state_q)
			ST_FIND, ST_QUERY: rd_en = (cnt_q < n_use);
			ST_COPY: begin
				rd_en     = (cnt_q <= e2_q);
				tmp_we    = act_s1;
				tmp_waddr = AW'(CW'(pos_s1) - s2_q);
			end
			ST_SHIFT: begin
				rd_en   = (cnt_q != e1_q);
				wr_en   = act_s1;
				wr_addr = AW'(CW'(pos_s1) + len_q);
				wr_data = word;
			end
			ST_PUT: begin
				tmp_rd_en = (cnt_q < len_q);
				wr_en     = act_s1;
				wr_addr   = AW'(e1_q + CW'(1) + CW'(pos_s1));
				wr_data   = {tdata_s1, (CW'(pos_s1) != len_q - CW'(1))};
			end
			ST_LINK: begin
				wr_en   = 1'b1;
				wr_addr = e1_q[AW-1:0];
				wr_data = {lab1_q, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_s1 <= mem[rd_addr];
		if (tmp_we) tmp[tmp_waddr] <= lab;
		if (tmp_rd_en) tdata_s1 <= tmp[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			act_s1  <= 1'b0;
			vld_s1  <= 1'b0;
			pos_s1  <= '0;
		end else begin
			act_s1 <= rd_en || tmp_rd_en;
			vld_s1 <= valid_q[rd_addr];
			pos_s1 <= rd_addr;
			if (accept && req_type == REQ_CLEAR) valid_q <= '0;
			else if (wr_en) valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			n_vertices_q   <= CFG_W'(64);
			anchor_q       <= '0;
			inside_q       <= 1'b0;
			vert_q         <= '0;
			cnt_q          <= '0;
			fa_q           <= 1'b0;
			fb_q           <= 1'b0;
			pa_q           <= 1'b0;
			pb_q           <= 1'b0;
			sa_q           <= '0;
			sb_q           <= '0;
			ea_q           <= '0;
			eb_q           <= '0;
			la_q           <= '0;
			lb_q           <= '0;
			cur_start_q    <= '0;
			e1_q           <= '0;
			s2_q           <= '0;
			e2_q           <= '0;
			len_q          <= '0;
			lab1_q         <= '0;
			min_q          <= '0;
			fresh_q        <= 1'b1;
			strobe         <= 1'b0;
			representative <= '0;
			last_of_run    <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (cfg_we) n_vertices_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					cnt_q       <= '0;
					fa_q        <= 1'b0;
					fb_q        <= 1'b0;
					pa_q        <= 1'b0;
					pb_q        <= 1'b0;
					cur_start_q <= '0;
					fresh_q     <= 1'b1;
					if (accept) begin
						case (req_type)
							REQ_PERM: begin
								inside_q <= cycle_continues;
								vert_q   <= vertex;
								if (!inside_q) anchor_q <= vertex;
								else state_q <= ST_FIND;
							end
							REQ_QUERY: state_q <= ST_QUERY;
							REQ_CLEAR: begin
								anchor_q <= '0;
								inside_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_FIND: begin
					if (rd_en) cnt_q <= cnt_q + CW'(1);
					if (act_s1) begin
						if (hit_a) begin
							fa_q <= 1'b1;
							sa_q <= cur_start_q;
						end
						if (hit_b) begin
							fb_q <= 1'b1;
							sb_q <= cur_start_q;
						end
						if (cell_end) begin
							cur_start_q <= pos_s1 + AW'(1);
							pa_q <= 1'b0;
							pb_q <= 1'b0;
							if (hit_a || pa_q) begin
								ea_q <= pos_s1;
								la_q <= lab;
							end
							if (hit_b || pb_q) begin
								eb_q <= pos_s1;
								lb_q <= lab;
							end
						end else begin
							if (hit_a) pa_q <= 1'b1;
							if (hit_b) pb_q <= 1'b1;
						end
						if (last_pos) state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!fa_q || !fb_q || sa_q == sb_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_COPY;
						if (sa_q < sb_q) begin
							e1_q   <= CW'(ea_q);
							lab1_q <= la_q;
							s2_q   <= CW'(sb_q);
							e2_q   <= CW'(eb_q);
							len_q  <= CW'(eb_q) - CW'(sb_q) + CW'(1);
							cnt_q  <= CW'(sb_q);
						end else begin
							e1_q   <= CW'(eb_q);
							lab1_q <= lb_q;
							s2_q   <= CW'(sa_q);
							e2_q   <= CW'(ea_q);
							len_q  <= CW'(ea_q) - CW'(sa_q) + CW'(1);
							cnt_q  <= CW'(sa_q);
						end
					end
				end
				ST_COPY: begin
					if (rd_en) cnt_q <= cnt_q + CW'(1);
					if (act_s1 && CW'(pos_s1) == e2_q) begin
						if (s2_q == e1_q + CW'(1)) begin
							state_q <= ST_PUT;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_SHIFT;
							cnt_q   <= s2_q - CW'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (rd_en) cnt_q <= cnt_q - CW'(1);
					if (act_s1 && CW'(pos_s1) == e1_q + CW'(1)) begin
						state_q <= ST_PUT;
						cnt_q   <= '0;
					end
				end
				ST_PUT: begin
					if (tmp_rd_en) cnt_q <= cnt_q + CW'(1);
					if (act_s1 && CW'(pos_s1) == len_q - CW'(1)) state_q <= ST_LINK;
				end
				ST_LINK: state_q <= ST_IDLE;
				ST_QUERY: begin
					if (rd_en) cnt_q <= cnt_q + CW'(1);
					if (act_s1) begin
						if (cell_end) begin
							strobe         <= 1'b1;
							representative <= minv;
							last_of_run    <= last_pos;
							fresh_q        <= 1'b1;
						end else begin
							min_q   <= minv;
							fresh_q <= 1'b0;
						end
						if (last_pos) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/opm_checker.sv */
// opm_checker: port-level checks for orbit_partition_merge, bound to the top
// depends on opm_pkg
`timescale 1ns / 1ps
module opm_checker
	import opm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [REQ_W-1:0]   req_type,
	input logic               strobe,
	input logic               last_of_run
);

	// results only come out of a query in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a query in progress");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_QUERY) |=> busy)
		else $error("query request did not occupy the block");

	a_clear_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_CLEAR || req_type == REQ_NONE)) |=> !busy)
		else $error("clear or unused request kept the block busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_of_run) |=> !strobe)
		else $error("result right after the last one of a query");

endmodule

bind orbit_partition_merge opm_checker u_opm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.req_type    (req_type),
	.strobe      (strobe),
	.last_of_run (last_of_run)
);

/* dv/orbit_partition_merge_tb.sv */
// orbit_partition_merge_tb: random and directed requests against the orbit
// partition merge block, with a scoreboard that predicts every cell minimum
// depends on opm_pkg and orbit_partition_merge
`timescale 1ns / 1ps

module orbit_partition_merge_tb;
	import opm_pkg::*;

	localparam int NV = 64;

	class orbit_scoreboard;
		logic [LABEL_W-1:0] labels [NV];
		bit                 links [NV];
		logic [LABEL_W-1:0] anchor;
		bit                 in_cycle;
		logic [CFG_W-1:0]   n_reg;
		logic [LABEL_W:0]   exp_min [$];
		int                 errors;

		function new();
			n_reg = 7'd64;
			errors = 0;
			discrete();
		endfunction

		function void discrete();
			for (int i = 0; i < NV; i++) begin
				labels[i] = i[LABEL_W-1:0];
				links[i] = 0;
			end
			anchor = '0;
			in_cycle = 0;
		endfunction

		function int used();
			int n;
			n = n_reg;
			if (n < 1) n = 1;
			if (n > NV) n = NV;
			return n;
		endfunction

		function int cell_start(logic [LABEL_W-1:0] v, int n);
			int s;
			s = 0;
			for (int j = 0; j < n; j++) begin
				if (labels[j] == v) return s;
				if (j + 1 >= n || !links[j]) s = j + 1;
			end
			return -1;
		endfunction

		function int cell_len(int s, int n);
			int j;
			j = s;
			while (j + 1 < n && links[j]) j++;
			return j - s + 1;
		endfunction

		function void merge(logic [LABEL_W-1:0] va, logic [LABEL_W-1:0] vb, int n);
			int a, b, s1, s2, l1, l2, mid;
			logic [LABEL_W-1:0] tl [NV];
			bit tk [NV];
			a = cell_start(va, n);
			b = cell_start(vb, n);
			if (a < 0 || b < 0 || a == b) return;
			s1 = (a < b) ? a : b;
			s2 = (a < b) ? b : a;
			l1 = cell_len(s1, n);
			l2 = cell_len(s2, n);
			mid = s2 - (s1 + l1);
			for (int i = 0; i < l2; i++) begin
				tl[i] = labels[s2 + i];
				tk[i] = links[s2 + i];
			end
			tk[l2 - 1] = 0;
			for (int i = mid - 1; i >= 0; i--) begin
				labels[s1 + l1 + l2 + i] = labels[s1 + l1 + i];
				links[s1 + l1 + l2 + i] = links[s1 + l1 + i];
			end
			for (int i = 0; i < l2; i++) begin
				labels[s1 + l1 + i] = tl[i];
				links[s1 + l1 + i] = tk[i];
			end
			links[s1 + l1 - 1] = 1;
		endfunction

		function void note_request(req_t r, logic [LABEL_W-1:0] v, bit c);
			int n;
			logic [LABEL_W-1:0] m;
			bit fresh;
			n = used();
			case (r)
				REQ_PERM: begin
					if (!in_cycle) anchor = v;
					else merge(anchor, v, n);
					in_cycle = c;
				end
				REQ_QUERY: begin
					fresh = 1;
					m = '0;
					for (int j = 0; j < n; j++) begin
						if (fresh || labels[j] < m) m = labels[j];
						fresh = 0;
						if (j + 1 >= n || !links[j]) begin
							exp_min.push_back({m, bit'(j + 1 >= n)});
							fresh = 1;
						end
					end
				end
				REQ_CLEAR: discrete();
				default: ;
			endcase
		endfunction

		function void check_result(logic [LABEL_W-1:0] rep, logic last);
			logic [LABEL_W:0] e;
			if (exp_min.size() == 0) begin
				$display("%0t: unexpected result rep %0d last %0d", $time, rep, last);
				errors++;
				return;
			end
			e = exp_min.pop_front();
			if (rep !== e[LABEL_W:1]) begin
				$display("%0t: representative expected %0d actual %0d", $time,
					e[LABEL_W:1], rep);
				errors++;
			end
			if (last !== e[0]) begin
				$display("%0t: last_of_run expected %0d actual %0d", $time, e[0], last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [REQ_W-1:0]   req_type = '0;
	logic [LABEL_W-1:0] vertex = '0;
	logic               cycle_continues = 0;
	logic               cfg_we = 0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               strobe;
	logic [LABEL_W-1:0] representative;
	logic               last_of_run;

	orbit_scoreboard sb = new();
	bit idling = 1;
	int n_now = 64;

	orbit_partition_merge #(.MAX_VERTICES(NV)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .vertex(vertex), .cycle_continues(cycle_continues),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe),
		.representative(representative), .last_of_run(last_of_run)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.n_reg = cfg_wdata;
			if (strobe) sb.check_result(representative, last_of_run);
			if (start && !busy)
				sb.note_request(req_t'(req_type), vertex, cycle_continues);
		end
	end

	task automatic send(req_t r, logic [LABEL_W-1:0] v, bit c);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		req_type <= r;
		vertex <= v;
		cycle_continues <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 0;
		do @(posedge clk); while (busy || sb.exp_min.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_vertices(logic [CFG_W-1:0] val);
		wait_idle();
		cfg_we <= 1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		n_now = (val < 1) ? 1 : (val > NV) ? NV : val;
	endtask

	// one well-formed cycle of 2..5 entries, mostly within the used vertices
	task automatic send_cycle();
		int len;
		logic [LABEL_W-1:0] v;
		len = $urandom_range(2, 5);
		for (int i = 0; i < len; i++) begin
			v = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 63)) :
				LABEL_W'($urandom_range(0, n_now - 1));
			send(REQ_PERM, v, i != len - 1);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [8];
		int pick;
		sizes = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd13, 7'd33, 7'd2};
		repeat (4) @(negedge clk);
		arst_n <= 1;

		send(REQ_QUERY, 6'd0, 0);
		send(REQ_PERM, 6'd63, 1);
		send(REQ_PERM, 6'd0, 1);
		send(REQ_PERM, 6'd63, 1);
		send(REQ_PERM, 6'd10, 0);
		send(REQ_QUERY, 6'd63, 1);
		send(REQ_PERM, 6'd20, 1);
		send(REQ_QUERY, 6'd0, 0);
		send(REQ_PERM, 6'd5, 0);
		send(REQ_NONE, 6'd42, 1);
		send(REQ_QUERY, 6'd0, 0);
		send(REQ_CLEAR, 6'd0, 0);
		send(REQ_QUERY, 6'd0, 0);
		set_vertices(7'd4);
		send(REQ_PERM, 6'd3, 1);
		send(REQ_PERM, 6'd50, 1);
		send(REQ_PERM, 6'd0, 0);
		send(REQ_QUERY, 6'd0, 0);
		send(REQ_PERM, 6'd1, 1);
		send(REQ_CLEAR, 6'd0, 1);
		send(REQ_PERM, 6'd2, 0);
		send(REQ_QUERY, 6'd0, 0);

		for (int p = 0; p < 8; p++) begin
			set_vertices(sizes[p]);
			if (p == 6) idling = 0;
			for (int k = 0; k < 14; k++) begin
				pick = $urandom_range(0, 19);
				if (pick < 13) send_cycle();
				else if (pick < 17) send(REQ_QUERY, LABEL_W'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
				else if (pick < 18) send(REQ_CLEAR, LABEL_W'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
				else send(req_t'(REQ_W'($urandom_range(0, 3))),
					LABEL_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end
			send(REQ_QUERY, 6'd0, 0);
		end

		wait_idle();
		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.exp_min.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
